/* hw/rtl/rpn_pkg.sv */
// Shared types, codes and defaults for the reverse Polish calculator core.
// No dependencies; used by rpn_ctrl, rpn_dp, rpn_div and the top level.
package rpn_pkg;

    // Default sizing of the operand stack and of the fixed-point format.
    localparam int STACK_DEPTH_DEF   = 128;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_W           = 32;

    // Token codes carried on the input tuser.
    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_PUSH  = 3'd0;
    localparam opcode_t OP_ADD   = 3'd1;
    localparam opcode_t OP_SUB   = 3'd2;
    localparam opcode_t OP_MUL   = 3'd3;
    localparam opcode_t OP_DIV   = 3'd4;
    localparam opcode_t OP_PRINT = 3'd5;

    // Result status codes carried on the output tuser.
    typedef logic [2:0] status_t;
    localparam status_t ST_VALUE   = 3'd0;
    localparam status_t ST_FULL    = 3'd1;
    localparam status_t ST_EMPTY   = 3'd2;
    localparam status_t ST_DIV0    = 3'd3;
    localparam status_t ST_UNKNOWN = 3'd4;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_B,
        S_LOAD_B,
        S_ERR_B,
        S_POP_A,
        S_LOAD_A,
        S_ERR_A,
        S_EXEC,
        S_DIV_WAIT,
        S_PUSH_RES,
        S_EMIT_VAL,
        S_ERR_DIV0,
        S_ERR_FULL,
        S_ERR_UNK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;      // capture the accepted token
        logic    push_operand;  // write the token operand on top, bump pointer
        logic    pop;           // read the top entry, drop pointer
        logic    clr_b;         // divisor/right operand reads as zero
        logic    ld_b;          // right operand from the read register
        logic    clr_a;
        logic    ld_a;
        logic    push_res;      // write the arithmetic result on top
        logic    div_start;
        logic    emit;          // load the output register
        status_t emit_status;
        logic    emit_last;
        logic    emit_use_b;    // emitted value is the popped operand, else zero
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t op;
        logic    sp_zero;
        logic    sp_full;
        logic    rdata_zero;
        logic    div_done;
        logic    out_free;
    } dp_sts_t;

endpackage

/* hw/rtl/rpn_div.sv */
// Restoring divider for fixed-point magnitudes, one quotient bit per cycle.
// Depends on rpn_pkg for the value width; instantiated by rpn_dp.
module rpn_div #(
    parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [rpn_pkg::VALUE_W-1:0]            dvd_mag,
    input  logic [rpn_pkg::VALUE_W-1:0]            dsr_mag,
    output logic [rpn_pkg::VALUE_W+FRACTION_BITS-1:0] quot,
    output logic                                   done
);

    localparam int VW = rpn_pkg::VALUE_W;
    localparam int DW = VW + FRACTION_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dq_reg;     // dividend bits shift out, quotient bits shift in
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   rem_sh;
    logic [VW:0]   diff;
    logic          qbit;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[DW-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        qbit   = ~diff[VW];
    end

    // Control: count DW steps after a start, pulse done on the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= DW'(dvd_mag) << FRACTION_BITS;
            rem_reg <= '0;
            dsr_reg <= dsr_mag;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DW-2:0], qbit};
            rem_reg <= qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
        end
    end

    assign quot = dq_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/rpn_dp.sv */
// Datapath of the calculator: token register, stack memory and pointer,
// operand registers, saturating arithmetic and the result register.
// Depends on rpn_pkg and rpn_div.
module rpn_dp #(
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rpn_pkg::dp_cmd_t            cmd,
    output rpn_pkg::dp_sts_t            sts,
    input  logic [2:0]                  in_opcode,
    input  logic [31:0]                 in_operand,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  out_status,
    output logic [31:0]                 out_value,
    output logic                        out_last
);

    localparam int VW  = rpn_pkg::VALUE_W;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DW  = VW + FRACTION_BITS;

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic [VW-1:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] negm;
        negm = ~mag + 64'd1;
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : negm[VW-1:0];
        else
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[VW-1:0];
    endfunction

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic [VW-1:0] sat_sum(input logic [VW:0] s);
        if (s[VW] != s[VW-1])
            return s[VW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            return s[VW-1:0];
    endfunction

    logic [VW-1:0]       mem [STACK_DEPTH];
    logic [VW-1:0]       rdata_reg;
    logic [SPW-1:0]      sp_reg;
    rpn_pkg::opcode_t    op_reg;
    logic [VW-1:0]       operand_reg;
    logic [VW-1:0]       a_reg;
    logic [VW-1:0]       b_reg;
    logic [63:0]         prod_reg;
    logic                out_valid_reg;
    rpn_pkg::status_t    out_status_reg;
    logic [VW-1:0]       out_value_reg;
    logic                out_last_reg;

    logic [SPW-1:0]      sp_dec;
    logic [VW-1:0]       mag_a;
    logic [VW-1:0]       mag_b;
    logic                neg;
    logic [63:0]         prod_next;
    logic [VW:0]         sum_add;
    logic [VW:0]         sum_sub;
    logic [DW-1:0]       quot;
    logic                div_done;
    logic [VW-1:0]       res_value;
    logic [VW-1:0]       wr_data;

    assign sp_dec = sp_reg - SPW'(1);

    // Operand magnitudes and product sign.
    always_comb
    begin
        mag_a     = a_reg[VW-1] ? (~a_reg + VW'(1)) : a_reg;
        mag_b     = b_reg[VW-1] ? (~b_reg + VW'(1)) : b_reg;
        neg       = a_reg[VW-1] ^ b_reg[VW-1];
        prod_next = mag_a * mag_b;
        sum_add   = {a_reg[VW-1], a_reg} + {b_reg[VW-1], b_reg};
        sum_sub   = {a_reg[VW-1], a_reg} - {b_reg[VW-1], b_reg};
    end

    rpn_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dvd_mag (mag_a),
        .dsr_mag (mag_b),
        .quot    (quot),
        .done    (div_done)
    );

    // Result of the arithmetic token, selected by opcode.
    always_comb
    begin
        case (op_reg)
            rpn_pkg::OP_ADD: res_value = sat_sum(sum_add);
            rpn_pkg::OP_SUB: res_value = sat_sum(sum_sub);
            rpn_pkg::OP_MUL: res_value = sat_mag(neg, prod_reg >> FRACTION_BITS);
            default:         res_value = sat_mag(neg, 64'(quot));
        endcase
        wr_data = cmd.push_operand ? operand_reg : res_value;
    end

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push_operand || cmd.push_res)
            mem[sp_reg[AW-1:0]] <= wr_data;
        if (cmd.pop)
            rdata_reg <= mem[sp_dec[AW-1:0]];
    end

    // Stack pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else if (cmd.push_operand || cmd.push_res)
            sp_reg <= sp_reg + SPW'(1);
        else if (cmd.pop)
            sp_reg <= sp_dec;
    end

    // Token and operand registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg      <= in_opcode;
            operand_reg <= in_operand;
        end
        if (cmd.clr_b)
            b_reg <= '0;
        else if (cmd.ld_b)
            b_reg <= rdata_reg;
        if (cmd.clr_a)
            a_reg <= '0;
        else if (cmd.ld_a)
            a_reg <= rdata_reg;
        prod_reg <= prod_next;
    end

    // Result register: holds one transfer until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_value_reg  <= cmd.emit_use_b ? b_reg : '0;
            out_last_reg   <= cmd.emit_last;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.op         = op_reg;
        sts.sp_zero    = (sp_reg == '0);
        sts.sp_full    = (sp_reg == SPW'(STACK_DEPTH));
        sts.rdata_zero = (rdata_reg == '0);
        sts.div_done   = div_done;
        sts.out_free   = ~out_valid_reg | out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;

endmodule

/* hw/rtl/rpn_ctrl.sv */
// Controller state machine of the calculator: sequences pops, arithmetic,
// pushes and result transfers. Depends on rpn_pkg; drives rpn_dp.
module rpn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rpn_pkg::dp_sts_t sts,
    output rpn_pkg::dp_cmd_t cmd
);

    rpn_pkg::state_t state_reg;
    rpn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rpn_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            rpn_pkg::S_IDLE:
                if (in_valid)
                    state_next = rpn_pkg::S_DECODE;
            rpn_pkg::S_DECODE:
                unique case (sts.op) inside
                    rpn_pkg::OP_PUSH:
                        state_next = sts.sp_full ? rpn_pkg::S_ERR_FULL : rpn_pkg::S_IDLE;
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
                    rpn_pkg::OP_DIV, rpn_pkg::OP_PRINT:
                        state_next = rpn_pkg::S_POP_B;
                    default:
                        state_next = rpn_pkg::S_ERR_UNK;
                endcase
            rpn_pkg::S_POP_B:
                state_next = sts.sp_zero ? rpn_pkg::S_ERR_B : rpn_pkg::S_LOAD_B;
            rpn_pkg::S_LOAD_B:
                if (sts.op == rpn_pkg::OP_PRINT)
                    state_next = rpn_pkg::S_EMIT_VAL;
                else if (sts.op == rpn_pkg::OP_DIV && sts.rdata_zero)
                    state_next = rpn_pkg::S_ERR_DIV0;
                else
                    state_next = rpn_pkg::S_POP_A;
            rpn_pkg::S_ERR_B:
                if (sts.out_free)
                begin
                    if (sts.op == rpn_pkg::OP_PRINT)
                        state_next = rpn_pkg::S_EMIT_VAL;
                    else if (sts.op == rpn_pkg::OP_DIV)
                        state_next = rpn_pkg::S_ERR_DIV0;
                    else
                        state_next = rpn_pkg::S_POP_A;
                end
            rpn_pkg::S_POP_A:
                state_next = sts.sp_zero ? rpn_pkg::S_ERR_A : rpn_pkg::S_LOAD_A;
            rpn_pkg::S_LOAD_A:
                state_next = rpn_pkg::S_EXEC;
            rpn_pkg::S_ERR_A:
                if (sts.out_free)
                    state_next = rpn_pkg::S_EXEC;
            rpn_pkg::S_EXEC:
                state_next = (sts.op == rpn_pkg::OP_DIV) ? rpn_pkg::S_DIV_WAIT
                                                         : rpn_pkg::S_PUSH_RES;
            rpn_pkg::S_DIV_WAIT:
                if (sts.div_done)
                    state_next = rpn_pkg::S_PUSH_RES;
            rpn_pkg::S_PUSH_RES:
                state_next = rpn_pkg::S_IDLE;
            rpn_pkg::S_EMIT_VAL,
            rpn_pkg::S_ERR_DIV0,
            rpn_pkg::S_ERR_FULL,
            rpn_pkg::S_ERR_UNK:
                if (sts.out_free)
                    state_next = rpn_pkg::S_IDLE;
            default:
                state_next = rpn_pkg::S_IDLE;
        endcase
    end

    // Output logic: datapath commands per state.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            rpn_pkg::S_DECODE:
                cmd.push_operand = (sts.op == rpn_pkg::OP_PUSH) && !sts.sp_full;
            rpn_pkg::S_POP_B:
            begin
                cmd.pop   = ~sts.sp_zero;
                cmd.clr_b = sts.sp_zero;
            end
            rpn_pkg::S_LOAD_B:
                cmd.ld_b = 1'b1;
            rpn_pkg::S_ERR_B:
            begin
                // An empty right operand is never the final result.
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_EMPTY;
            end
            rpn_pkg::S_POP_A:
            begin
                cmd.pop   = ~sts.sp_zero;
                cmd.clr_a = sts.sp_zero;
            end
            rpn_pkg::S_LOAD_A:
                cmd.ld_a = 1'b1;
            rpn_pkg::S_ERR_A:
            begin
                // The push that follows always fits, so this one ends the token.
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_EMPTY;
                cmd.emit_last   = 1'b1;
            end
            rpn_pkg::S_EXEC:
                cmd.div_start = (sts.op == rpn_pkg::OP_DIV);
            rpn_pkg::S_DIV_WAIT:
                cmd = '0;
            rpn_pkg::S_PUSH_RES:
                cmd.push_res = 1'b1;
            rpn_pkg::S_EMIT_VAL:
            begin
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_VALUE;
                cmd.emit_last   = 1'b1;
                cmd.emit_use_b  = 1'b1;
            end
            rpn_pkg::S_ERR_DIV0:
            begin
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_DIV0;
                cmd.emit_last   = 1'b1;
            end
            rpn_pkg::S_ERR_FULL:
            begin
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_FULL;
                cmd.emit_last   = 1'b1;
            end
            rpn_pkg::S_ERR_UNK:
            begin
                cmd.emit        = sts.out_free;
                cmd.emit_status = rpn_pkg::ST_UNKNOWN;
                cmd.emit_last   = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/rpn_stack_calculator_core.sv */
// Reverse Polish calculator core: one token per input transfer, results on
// the output stream. Signed fixed-point values on an operand stack in memory.
// The slave stream carries tokens (tuser = opcode, tdata = operand), the
// master stream carries results (tuser = status, tdata = value, tlast marks
// the final result of a token). Tokens are handled one at a time.
// Per token, with a free output: a push is decoded and written to the stack;
// an unknown command or a push to a full stack emits its status; print pops
// and emits the value; divide by zero pops the divisor and emits its status;
// add, subtract and multiply pop both operands, compute and push the result;
// divide also waits for the restoring divider, which yields one quotient bit
// per cycle. An empty pop takes the place of its stack read. Stack reads go
// through the registered read port of the stack memory.
// A result sits in an output register; the next token is accepted while it
// waits. When the receiver stalls, a token that produces a further result
// waits in its emit state until the register frees up.
// Reset empties the stack (the pointer clears; memory contents are kept)
// and drops any pending result. No clearing pass is needed.
// Depends on rpn_pkg, rpn_ctrl, rpn_dp and rpn_div.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    rpn_pkg::dp_cmd_t cmd;
    rpn_pkg::dp_sts_t sts;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_axis_tuser),
        .in_operand (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_value  (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // A result is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("result loaded over a pending transfer");

    // Pops never happen on an empty stack, pushes never on a full one.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |-> !sts.sp_zero)
        else $error("pop from empty stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_res || cmd.push_operand) |-> !sts.sp_full)
        else $error("push to full stack");

    // A divider start is for a divide token and does not raise done straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done && sts.op == rpn_pkg::OP_DIV)
        else $error("divider started for a token that is not a divide");
`endif

endmodule
